[hdl/sgs_pkg.sv]
package sgs_pkg;

   // Request codes
   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_STEP  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Control register indexes
   localparam int CSR_BITS      = 3;
   localparam int CSR_DATA_BITS = 48;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_TIME      = 3'd0,
      CSR_FIELD     = 3'd1,
      CSR_POTENTIAL = 3'd2,
      CSR_SCHEME    = 3'd3,
      CSR_GRID_X    = 3'd4,
      CSR_GRID_Y    = 3'd5
   } csr_index_type;

   // Rounding shift of the shared multiplier
   typedef enum logic [2:0] {
      SH_FIELD,   // 28 fraction bits
      SH_POT,     // 48 fraction bits
      SH_TIME,    // 24 fraction bits
      SH_DENS,    // 30 fraction bits
      SH_RAW      // plain low 64 bits, no rounding
   } mul_shift_type;

   // Multiply operations issued by the sequencer
   typedef enum logic [3:0] {
      OP_G,    // potential weight for the point
      OP_FR,   // field term, real
      OP_FI,   // field term, imaginary
      OP_PR,   // potential term, real
      OP_PI,   // potential term, imaginary
      OP_TR,   // time scaling, real
      OP_TI,   // time scaling, imaginary
      OP_DR,   // corner density, real square
      OP_DI    // corner density, imaginary square
   } op_type;

   localparam logic signed [63:0] SAT_LIM = 64'sd1 <<< 61;

   // Saturate an intermediate to +-2^61
   function automatic logic signed [63:0] clamp_lim(input logic signed [63:0] v);
      if (v > SAT_LIM) begin
         return SAT_LIM;
      end
      if (v < -SAT_LIM) begin
         return -SAT_LIM;
      end
      return v;
   endfunction

endpackage

[hdl/schrodinger_grid_stencil_step_core.sv]
// Channel    Ports                                      Handshake
// request    req_action .. req_query_y                start high while busy low
// result     rsp_density, rsp_status                  rsp_valid strobe, one cycle
// control    csr_index, csr_wdata                     csr_we, taken at once
//
// After reset a clearing pass writes zero to all GRID_MAX*GRID_MAX entries of all
// three banks, with busy high; control writes are taken during it.
// A step sweeps every point once: it zeroes each edge point, and for each
// interior point it makes five reads through the single read port of the current
// bank, then seven calls of the shared 4-pass 32x32 multiplier.
// The result strobe cannot be held off; one request is in flight at a time.
module schrodinger_grid_stencil_step_core #(
   parameter int GRID_MAX   = 128,
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [6:0]                         req_point_x,
   input  logic [6:0]                         req_point_y,
   input  logic signed [31:0]                 req_real_part,
   input  logic signed [31:0]                 req_imag_part,
   input  logic [14:0]                        req_query_x,
   input  logic [14:0]                        req_query_y,
   output logic                               rsp_valid,
   output logic [31:0]                        rsp_density,
   output logic                               rsp_status,
   input  logic                               csr_we,
   input  logic [sgs_pkg::CSR_BITS-1:0]       csr_index,
   input  logic [sgs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sgs_pkg::*;

   localparam int VB    = VALUE_BITS;
   localparam int DW    = 2 * VB;
   localparam int CW    = $clog2(GRID_MAX);
   localparam int GW    = CW + 1;
   localparam int AW    = 2 * CW;
   localparam int DEPTH = GRID_MAX * GRID_MAX;
   localparam int LPW   = VB + 4;
   localparam int CVW   = VB + CW + 3;
   localparam logic signed [63:0] VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
   localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

   typedef enum logic [16:0] {
      S_CLEAR = 17'h00001,
      S_IDLE  = 17'h00002,
      S_LOAD  = 17'h00004,
      S_SCAN  = 17'h00008,
      S_FETCH = 17'h00010,
      S_TERMS = 17'h00020,
      S_MUL   = 17'h00040,
      S_MWAIT = 17'h00080,
      S_WRITE = 17'h00100,
      S_ROT   = 17'h00200,
      S_QCHK  = 17'h00400,
      S_QRD   = 17'h00800,
      S_QCAP  = 17'h01000,
      S_QLO   = 17'h02000,
      S_QHI   = 17'h04000,
      S_QV    = 17'h08000,
      S_QOUT  = 17'h10000
   } state_type;

   function automatic logic signed [VB-1:0] w_re(input logic [DW-1:0] w);
      return signed'(w[VB-1:0]);
   endfunction

   function automatic logic signed [VB-1:0] w_im(input logic [DW-1:0] w);
      return signed'(w[DW-1:VB]);
   endfunction

   function automatic logic signed [VB-1:0] clamp_v(input logic signed [63:0] v);
      if (v > VMAX) begin
         return VB'(VMAX);
      end
      if (v < VMIN) begin
         return VB'(VMIN);
      end
      return VB'(v);
   endfunction

   function automatic logic [GW-1:0] eff_size(input logic [7:0] g);
      if (g < 8'd3) begin
         return GW'(3);
      end
      if (9'(g) > 9'(GRID_MAX)) begin
         return GW'(GRID_MAX);
      end
      return GW'(g);
   endfunction

   function automatic logic [AW-1:0] point_addr(input logic [7:0] x, input logic [7:0] y,
                                                input logic [GW-1:0] g);
      logic [17:0] t;
      t = 18'(x) * 18'(g) + 18'(y);
      return AW'(t);
   endfunction

   // Control registers
   logic [31:0]          time_coef_ff;
   logic signed [31:0]   field_coef_ff;
   logic [47:0]          pot_coef_ff;
   logic                 scheme_ff;
   logic [7:0]           grid_x_ff, grid_y_ff;

   // Sequencer state
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [1:0]           rot_ff, rot_in;
   logic [CW-1:0]        x_ff, x_in, y_ff, y_in;
   logic [AW-1:0]        p_ff, p_in;
   logic [2:0]           fc_ff, fc_in;
   logic [DW-1:0]        nb_ff [5];
   logic [DW-1:0]        nb_in [5];
   logic [DW-1:0]        prv_ff, prv_in;
   logic signed [LPW-1:0] lapr_ff, lapr_in, lapi_ff, lapi_in;
   logic signed [CVW-1:0] cvr_ff, cvr_in, cvi_ff, cvi_in;
   logic [63:0]          g_ff, g_in;
   logic signed [63:0]   br_ff, br_in, bi_ff, bi_in;
   logic signed [VB-1:0] nre_ff, nre_in, nim_ff, nim_in;
   op_type               op_ff, op_in;
   logic [1:0]           qk_ff, qk_in;
   logic [63:0]          dacc_ff, dacc_in;
   logic [31:0]          d_ff [4];
   logic [31:0]          d_in [4];
   logic [40:0]          lo_ff, lo_in, hi_ff, hi_in;
   logic [49:0]          v_ff, v_in;

   // Latched request
   logic [6:0]           pt_x_ff, pt_y_ff;
   logic signed [31:0]   ld_re_ff, ld_im_ff;
   logic [14:0]          qx_ff, qy_ff;

   // Result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_density_ff, rsp_density_in;
   logic                 rsp_status_ff, rsp_status_in;

   // Bank access
   logic                 wr_en, wr_cur, clr_we;
   logic [AW-1:0]        wr_addr, cur_raddr;
   logic [DW-1:0]        wr_data;
   logic [1:0]           cur_idx, nxt_idx, wr_bank;
   logic [DW-1:0]        cur_rdata, prev_rdata;
   logic [AW-1:0]        bank_raddr [3];
   logic                 bank_we    [3];
   logic [DW-1:0]        bank_rdata [3];

   // Shared multiplier
   logic                 mul_start, mul_done, mul_bneg;
   logic signed [63:0]   mul_a, mul_res;
   logic [63:0]          mul_b;
   mul_shift_type        mul_sh;

   // Misc decoded values
   logic [GW-1:0]        gx, gy;
   logic                 accept, is_edge, last_pt;
   logic [7:0]           fx, fy, xl, yl, xh, yh, cx, cy;
   logic                 q_out;
   logic [AW-1:0]        fetch_addr;
   logic [32:0]          tcoef;
   logic [DW-1:0]        ce, base;
   logic signed [CW:0]   xs, ys;
   logic signed [VB:0]   dyr, dxr, dyi, dxi;
   logic [2*CW:0]        rad2;
   logic signed [63:0]   re64, im64, corner_sum;
   logic [33:0]          dens_r;

   assign gx     = eff_size(grid_x_ff);
   assign gy     = eff_size(grid_y_ff);
   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_coef_ff  <= '0;
         field_coef_ff <= '0;
         pot_coef_ff   <= '0;
         scheme_ff     <= 1'b0;
         grid_x_ff     <= 8'd128;
         grid_y_ff     <= 8'd128;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME:      time_coef_ff  <= csr_wdata[31:0];
            CSR_FIELD:     field_coef_ff <= signed'(csr_wdata[31:0]);
            CSR_POTENTIAL: pot_coef_ff   <= csr_wdata[47:0];
            CSR_SCHEME:    scheme_ff     <= csr_wdata[0];
            CSR_GRID_X:    grid_x_ff     <= csr_wdata[7:0];
            CSR_GRID_Y:    grid_y_ff     <= csr_wdata[7:0];
            default:       ;
         endcase
      end
   end

   // Bank roles: previous is bank rot, current the next one, next the one after
   always_comb begin
      case (rot_ff)
         2'd0:    begin cur_idx = 2'd1; nxt_idx = 2'd2; end
         2'd1:    begin cur_idx = 2'd2; nxt_idx = 2'd0; end
         default: begin cur_idx = 2'd0; nxt_idx = 2'd1; end
      endcase
      wr_bank = wr_cur ? cur_idx : nxt_idx;
      case (cur_idx)
         2'd0:    cur_rdata = bank_rdata[0];
         2'd1:    cur_rdata = bank_rdata[1];
         default: cur_rdata = bank_rdata[2];
      endcase
      case (rot_ff)
         2'd0:    prev_rdata = bank_rdata[0];
         2'd1:    prev_rdata = bank_rdata[1];
         default: prev_rdata = bank_rdata[2];
      endcase
   end

   for (genvar k = 0; k < 3; k++) begin : g_bank
      assign bank_raddr[k] = (rot_ff == 2'(k)) ? p_ff : cur_raddr;
      assign bank_we[k]    = clr_we || (wr_en && wr_bank == 2'(k));

      sgs_bank #(
         .DEPTH (DEPTH),
         .AW    (AW),
         .DW    (DW)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[k]),
         .waddr (clr_we ? clr_ff : wr_addr),
         .wdata (clr_we ? '0 : wr_data),
         .raddr (bank_raddr[k]),
         .rdata (bank_rdata[k])
      );
   end

   // Query corners
   always_comb begin
      xl    = {1'b0, qx_ff[14:8]};
      yl    = {1'b0, qy_ff[14:8]};
      fx    = qx_ff[7:0];
      fy    = qy_ff[7:0];
      xh    = xl + 8'(fx != 8'd0);
      yh    = yl + 8'(fy != 8'd0);
      q_out = (9'(xh) >= 9'(gx)) || (9'(yh) >= 9'(gy));
      cx    = qk_ff[0] ? xh : xl;
      cy    = qk_ff[1] ? yh : yl;
   end

   // Stencil neighbor addresses
   always_comb begin
      case (fc_ff)
         3'd1:    fetch_addr = p_ff + AW'(gy);
         3'd2:    fetch_addr = p_ff - AW'(gy);
         3'd3:    fetch_addr = p_ff + AW'(1);
         3'd4:    fetch_addr = p_ff - AW'(1);
         default: fetch_addr = p_ff;
      endcase
      if (state_ff == S_QRD) begin
         cur_raddr = point_addr(cx, cy, gy);
      end else if (state_ff == S_FETCH) begin
         cur_raddr = fetch_addr;
      end else begin
         cur_raddr = p_ff;
      end
   end

   // Multiplier operand select
   always_comb begin
      ce    = nb_ff[0];
      base  = scheme_ff ? prv_ff : nb_ff[0];
      tcoef = scheme_ff ? {time_coef_ff, 1'b0} : {1'b0, time_coef_ff};
      rad2  = (2*CW+1)'(x_ff * x_ff) + (2*CW+1)'(y_ff * y_ff);
      re64  = 64'(w_re(ce));
      im64  = 64'(w_im(ce));
      mul_a    = '0;
      mul_b    = '0;
      mul_bneg = 1'b0;
      mul_sh   = SH_RAW;
      case (op_ff)
         OP_G: begin
            mul_a = signed'(64'(pot_coef_ff));
            mul_b = 64'(rad2);
         end
         OP_FR, OP_FI: begin
            mul_a    = (op_ff == OP_FR) ? 64'(cvr_ff) : 64'(cvi_ff);
            mul_b    = {32'd0, field_coef_ff[31] ? 32'(-field_coef_ff)
                                                 : 32'(field_coef_ff)};
            mul_bneg = field_coef_ff[31];
            mul_sh   = SH_FIELD;
         end
         OP_PR, OP_PI: begin
            mul_a  = (op_ff == OP_PR) ? im64 : re64;
            mul_b  = g_ff;
            mul_sh = SH_POT;
         end
         OP_TR, OP_TI: begin
            mul_a  = (op_ff == OP_TR) ? br_ff : bi_ff;
            mul_b  = 64'(tcoef);
            mul_sh = SH_TIME;
         end
         OP_DR, OP_DI: begin
            mul_a    = (op_ff == OP_DR) ? re64 : im64;
            mul_b    = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
            mul_bneg = mul_a[63];
            mul_sh   = SH_DENS;
         end
         default: ;
      endcase
   end

   sgs_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .bneg   (mul_bneg),
      .shift  (mul_sh),
      .done   (mul_done),
      .result (mul_res)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      rot_in   = rot_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      p_in     = p_ff;
      fc_in    = fc_ff;
      nb_in    = nb_ff;
      prv_in   = prv_ff;
      lapr_in  = lapr_ff;
      lapi_in  = lapi_ff;
      cvr_in   = cvr_ff;
      cvi_in   = cvi_ff;
      g_in     = g_ff;
      br_in    = br_ff;
      bi_in    = bi_ff;
      nre_in   = nre_ff;
      nim_in   = nim_ff;
      op_in    = op_ff;
      qk_in    = qk_ff;
      dacc_in  = dacc_ff;
      d_in     = d_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      v_in     = v_ff;
      rsp_valid_in   = 1'b0;
      rsp_density_in = rsp_density_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en     = 1'b0;
      wr_cur    = 1'b0;
      wr_addr   = p_ff;
      wr_data   = '0;
      clr_we    = 1'b0;
      mul_start = 1'b0;

      is_edge = (x_ff == '0) || (y_ff == '0) ||
                (GW'(x_ff) == gx - GW'(1)) || (GW'(y_ff) == gy - GW'(1));
      last_pt = (GW'(x_ff) == gx - GW'(1)) && (GW'(y_ff) == gy - GW'(1));

      xs  = signed'({1'b0, x_ff});
      ys  = signed'({1'b0, y_ff});
      dyr = (VB+1)'(w_re(nb_ff[3])) - (VB+1)'(w_re(nb_ff[4]));
      dxr = (VB+1)'(w_re(nb_ff[1])) - (VB+1)'(w_re(nb_ff[2]));
      dyi = (VB+1)'(w_im(nb_ff[3])) - (VB+1)'(w_im(nb_ff[4]));
      dxi = (VB+1)'(w_im(nb_ff[1])) - (VB+1)'(w_im(nb_ff[2]));

      corner_sum = signed'(dacc_ff) + mul_res;
      dens_r     = 34'((v_ff + 50'h8000) >> 16);

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep zero through all banks
            clr_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_LOAD:  state_in = S_LOAD;
                  ACT_STEP: begin
                     x_in     = '0;
                     y_in     = '0;
                     p_in     = '0;
                     state_in = S_SCAN;
                  end
                  ACT_QUERY: state_in = S_QCHK;
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_density_in = '0;
                     rsp_status_in  = 1'b0;
                  end
               endcase
            end
         end

         S_LOAD: begin
            // Write the current bank when the point lies in the grid
            rsp_valid_in   = 1'b1;
            rsp_density_in = '0;
            rsp_status_in  = 1'b1;
            if (8'(pt_x_ff) < 8'(gx) && 8'(pt_y_ff) < 8'(gy)) begin
               rsp_status_in = 1'b0;
               wr_en   = 1'b1;
               wr_cur  = 1'b1;
               wr_addr = point_addr({1'b0, pt_x_ff}, {1'b0, pt_y_ff}, gy);
               wr_data = {clamp_v(64'(ld_im_ff)), clamp_v(64'(ld_re_ff))};
            end
            state_in = S_IDLE;
         end

         S_SCAN: begin
            if (is_edge) begin
               // Zero the edge point and advance
               wr_en = 1'b1;
               if (last_pt) begin
                  state_in = S_ROT;
               end else begin
                  p_in = p_ff + AW'(1);
                  if (GW'(y_ff) == gy - GW'(1)) begin
                     y_in = '0;
                     x_in = x_ff + CW'(1);
                  end else begin
                     y_in = y_ff + CW'(1);
                  end
               end
            end else begin
               fc_in    = 3'd0;
               state_in = S_FETCH;
            end
         end

         S_FETCH: begin
            // Issue center and four neighbors, capture each read in the cycle after its issue
            if (fc_ff != 3'd0) begin
               nb_in[fc_ff - 3'd1] = cur_rdata;
            end
            if (fc_ff == 3'd1) begin
               prv_in = prev_rdata;
            end
            fc_in = fc_ff + 3'd1;
            if (fc_ff == 3'd5) begin
               state_in = S_TERMS;
            end
         end

         S_TERMS: begin
            lapr_in = LPW'(w_re(nb_ff[1])) + LPW'(w_re(nb_ff[2])) +
                      LPW'(w_re(nb_ff[3])) + LPW'(w_re(nb_ff[4])) -
                      (LPW'(w_re(nb_ff[0])) <<< 2);
            lapi_in = LPW'(w_im(nb_ff[1])) + LPW'(w_im(nb_ff[2])) +
                      LPW'(w_im(nb_ff[3])) + LPW'(w_im(nb_ff[4])) -
                      (LPW'(w_im(nb_ff[0])) <<< 2);
            cvr_in  = CVW'(xs) * CVW'(dyr) - CVW'(ys) * CVW'(dxr);
            cvi_in  = CVW'(xs) * CVW'(dyi) - CVW'(ys) * CVW'(dxi);
            op_in    = OP_G;
            state_in = S_MUL;
         end

         S_MUL: begin
            mul_start = 1'b1;
            state_in  = S_MWAIT;
         end

         S_MWAIT: begin
            // Fold the product into the point's terms, or into the query's corner density
            if (mul_done) begin
               state_in = S_MUL;
               case (op_ff)
                  OP_G: begin
                     g_in  = mul_res;
                     op_in = OP_FR;
                  end
                  OP_FR: begin
                     br_in = clamp_lim(-64'(lapi_ff) + mul_res);
                     op_in = OP_FI;
                  end
                  OP_FI: begin
                     bi_in = clamp_lim(64'(lapr_ff) + mul_res);
                     op_in = OP_PR;
                  end
                  OP_PR: begin
                     br_in = clamp_lim(br_ff + mul_res);
                     op_in = OP_PI;
                  end
                  OP_PI: begin
                     bi_in = clamp_lim(bi_ff - mul_res);
                     op_in = OP_TR;
                  end
                  OP_TR: begin
                     nre_in = clamp_v(64'(w_re(base)) + mul_res);
                     op_in  = OP_TI;
                  end
                  OP_TI: begin
                     nim_in   = clamp_v(64'(w_im(base)) + mul_res);
                     state_in = S_WRITE;
                  end
                  OP_DR: begin
                     dacc_in = mul_res;
                     op_in   = OP_DI;
                  end
                  default: begin
                     d_in[qk_ff] = (corner_sum > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF
                                                                 : corner_sum[31:0];
                     qk_in = qk_ff + 2'd1;
                     state_in = (qk_ff == 2'd3) ? S_QLO : S_QRD;
                  end
               endcase
            end
         end

         S_WRITE: begin
            // Store the new point and advance
            wr_en   = 1'b1;
            wr_data = {nim_ff, nre_ff};
            p_in    = p_ff + AW'(1);
            state_in = S_SCAN;
            if (GW'(y_ff) == gy - GW'(1)) begin
               y_in = '0;
               x_in = x_ff + CW'(1);
            end else begin
               y_in = y_ff + CW'(1);
            end
         end

         S_ROT: begin
            rot_in = (rot_ff == 2'd2) ? 2'd0 : rot_ff + 2'd1;
            rsp_valid_in   = 1'b1;
            rsp_density_in = '0;
            rsp_status_in  = 1'b0;
            state_in = S_IDLE;
         end

         S_QCHK: begin
            if (q_out) begin
               rsp_valid_in   = 1'b1;
               rsp_density_in = '0;
               rsp_status_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               qk_in    = 2'd0;
               state_in = S_QRD;
            end
         end

         S_QRD: begin
            state_in = S_QCAP;
         end

         S_QCAP: begin
            nb_in[0] = cur_rdata;
            op_in    = OP_DR;
            state_in = S_MUL;
         end

         S_QLO: begin
            lo_in = 41'(d_ff[0]) * 41'(9'd256 - 9'(fx)) + 41'(d_ff[1]) * 41'(fx);
            state_in = S_QHI;
         end

         S_QHI: begin
            hi_in = 41'(d_ff[2]) * 41'(9'd256 - 9'(fx)) + 41'(d_ff[3]) * 41'(fx);
            state_in = S_QV;
         end

         S_QV: begin
            v_in = 50'(lo_ff) * 50'(9'd256 - 9'(fy)) + 50'(hi_ff) * 50'(fy);
            state_in = S_QOUT;
         end

         S_QOUT: begin
            rsp_valid_in   = 1'b1;
            rsp_density_in = (dens_r > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : dens_r[31:0];
            rsp_status_in  = 1'b0;
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rot_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      fc_ff   <= fc_in;
      nb_ff   <= nb_in;
      prv_ff  <= prv_in;
      lapr_ff <= lapr_in;
      lapi_ff <= lapi_in;
      cvr_ff  <= cvr_in;
      cvi_ff  <= cvi_in;
      g_ff    <= g_in;
      br_ff   <= br_in;
      bi_ff   <= bi_in;
      nre_ff  <= nre_in;
      nim_ff  <= nim_in;
      op_ff   <= op_in;
      qk_ff   <= qk_in;
      dacc_ff <= dacc_in;
      d_ff    <= d_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      v_ff    <= v_in;
      rsp_density_ff <= rsp_density_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Hold the request fields
   always_ff @(posedge clock) begin
      if (accept) begin
         pt_x_ff  <= req_point_x;
         pt_y_ff  <= req_point_y;
         ld_re_ff <= req_real_part;
         ld_im_ff <= req_imag_part;
         qx_ff    <= req_query_x;
         qy_ff    <= req_query_y;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_density = rsp_density_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

[hdl/sgs_bank.sv]
module sgs_bank #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/sgs_mul.sv]
module sgs_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [63:0]     a,
   input  logic [63:0]            b,
   input  logic                   bneg,
   input  sgs_pkg::mul_shift_type shift,
   output logic                   done,
   output logic signed [63:0]     result
);
   import sgs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [63:0]          am_ff, am_in;
   logic [63:0]          b_ff, b_in;
   logic [127:0]         acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   mul_shift_type        sh_ff, sh_in;
   logic signed [63:0]   res_ff, res_in;

   logic [31:0]          ah, bh;
   logic [63:0]          pp;
   logic [127:0]         pp_sh;
   logic [127:0]         q;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      am_in   = am_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      res_in  = res_ff;

      // Select one 32x32 partial product
      ah = cnt_ff[1] ? am_ff[63:32] : am_ff[31:0];
      bh = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = 64'(ah) * 64'(bh);
      case (cnt_ff)
         2'd0:    pp_sh = 128'(pp);
         2'd3:    pp_sh = 128'(pp) << 64;
         default: pp_sh = 128'(pp) << 32;
      endcase

      // Round half away from zero, then drop fraction bits (SH_RAW: low 64 bits, no rounding)
      unique case (sh_ff)
         SH_FIELD: q = (acc_ff + (128'(1) << 27)) >> 28;
         SH_POT:   q = (acc_ff + (128'(1) << 47)) >> 48;
         SH_TIME:  q = (acc_ff + (128'(1) << 23)) >> 24;
         SH_DENS:  q = (acc_ff + (128'(1) << 29)) >> 30;
         SH_RAW:   q = 128'(acc_ff[63:0]);
         default:  q = 128'(acc_ff[63:0]);
      endcase
      if (sh_ff != SH_RAW && q > 128'(SAT_LIM)) begin
         q = 128'(SAT_LIM);
      end

      if (start) begin
         // Latch operands in sign-magnitude form
         am_in   = a[63] ? 64'(-a) : 64'(a);
         b_in    = b;
         neg_in  = a[63] ^ bneg;
         sh_in   = shift;
         acc_in  = '0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Accumulate partial products
         acc_in = acc_ff + pp_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         res_in  = neg_ff ? -signed'(q[63:0]) : signed'(q[63:0]);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      am_ff  <= am_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      sh_ff  <= sh_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import sgs_pkg::*;

   localparam int GMAX  = 128;
   localparam int CELLS = GMAX * GMAX;

   typedef struct {
      action_type  action;
      logic [6:0]  px;
      logic [6:0]  py;
      logic [31:0] re;
      logic [31:0] im;
      logic [14:0] qx;
      logic [14:0] qy;
   } request_type;

   typedef struct {
      logic [31:0] density;
      logic        status;
   } answer_type;

   // Wave field predictor and the queue of answers it has promised
   class field_scoreboard;
      longint      bank_re[3][CELLS];
      longint      bank_im[3][CELLS];
      int          rot;
      logic [31:0] tcoef;
      longint      bcoef;
      logic [63:0] pcoef;
      logic        ctcs;
      int          gx_reg, gy_reg;
      answer_type  pending[$];
      int          errors;

      function new();
         rot = 0; tcoef = 0; bcoef = 0; pcoef = 0; ctcs = 0;
         gx_reg = 128; gy_reg = 128; errors = 0;
         for (int b = 0; b < 3; b++)
            for (int i = 0; i < CELLS; i++) begin
               bank_re[b][i] = 0;
               bank_im[b][i] = 0;
            end
      endfunction

      function int grid_size(int g);
         if (g < 3) return 3;
         if (g > GMAX) return GMAX;
         return g;
      endfunction

      function void write_reg(csr_index_type idx, logic [47:0] v);
         case (idx)
            CSR_TIME:      tcoef = v[31:0];
            CSR_FIELD:     bcoef = longint'($signed(v[31:0]));
            CSR_POTENTIAL: pcoef = {16'd0, v};
            CSR_SCHEME:    ctcs = v[0];
            CSR_GRID_X:    gx_reg = int'(v[7:0]);
            CSR_GRID_Y:    gy_reg = int'(v[7:0]);
            default: ;
         endcase
      endfunction

      function longint limit61(longint v);
         if (v > SAT_LIM) return SAT_LIM;
         if (v < -SAT_LIM) return -SAT_LIM;
         return v;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Round |a|*b by sh bits, ties away from zero, limit to 2^61
      function longint scale_round(longint a, logic [63:0] b, int sh);
         logic [127:0] p;
         logic [63:0]  m;
         logic         neg;
         neg = a < 0;
         m = neg ? 64'(-a) : 64'(a);
         p = {64'd0, m} * {64'd0, b};
         p = (p + (128'd1 << (sh - 1))) >> sh;
         if (p > 128'(SAT_LIM)) p = 128'(SAT_LIM);
         return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
      endfunction

      function longint field_term(longint a);
         longint r;
         r = scale_round(a, bcoef < 0 ? 64'(-bcoef) : 64'(bcoef), 28);
         return bcoef < 0 ? -r : r;
      endfunction

      // Squared magnitude of one point, each square taken on the magnitude
      function logic [63:0] corner_power(int b, int idx);
         longint r, i, s;
         r = bank_re[b][idx] < 0 ? -bank_re[b][idx] : bank_re[b][idx];
         i = bank_im[b][idx] < 0 ? -bank_im[b][idx] : bank_im[b][idx];
         s = scale_round(r, 64'(r), 30) + scale_round(i, 64'(i), 30);
         if (64'(s) > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
         return 64'(s);
      endfunction

      // Advance the field one time step and zero the edges of the new field
      function void advance_field();
         int          gx, gy, pv, cu, nx, p;
         logic [63:0] c, g;
         longint      lr, li, cr, ci, br, bi, bre, bim;
         gx = grid_size(gx_reg);
         gy = grid_size(gy_reg);
         pv = rot; cu = (rot + 1) % 3; nx = (rot + 2) % 3;
         c = ctcs ? {31'd0, tcoef, 1'b0} : {32'd0, tcoef};
         for (int x = 1; x + 1 < gx; x++)
            for (int y = 1; y + 1 < gy; y++) begin
               p = x * gy + y;
               g = pcoef * 64'(x * x + y * y);
               lr = bank_re[cu][p + gy] + bank_re[cu][p - gy] + bank_re[cu][p + 1]
                  + bank_re[cu][p - 1] - 4 * bank_re[cu][p];
               li = bank_im[cu][p + gy] + bank_im[cu][p - gy] + bank_im[cu][p + 1]
                  + bank_im[cu][p - 1] - 4 * bank_im[cu][p];
               cr = longint'(x) * (bank_re[cu][p + 1] - bank_re[cu][p - 1])
                  - longint'(y) * (bank_re[cu][p + gy] - bank_re[cu][p - gy]);
               ci = longint'(x) * (bank_im[cu][p + 1] - bank_im[cu][p - 1])
                  - longint'(y) * (bank_im[cu][p + gy] - bank_im[cu][p - gy]);
               br = limit61(-li + field_term(cr));
               bi = limit61(lr + field_term(ci));
               br = limit61(br + scale_round(bank_im[cu][p], g, 48));
               bi = limit61(bi - scale_round(bank_re[cu][p], g, 48));
               bre = ctcs ? bank_re[pv][p] : bank_re[cu][p];
               bim = ctcs ? bank_im[pv][p] : bank_im[cu][p];
               bank_re[nx][p] = clamp32(bre + scale_round(br, c, 24));
               bank_im[nx][p] = clamp32(bim + scale_round(bi, c, 24));
            end
         for (int x = 0; x < gx; x++) begin
            bank_re[nx][x * gy] = 0;          bank_im[nx][x * gy] = 0;
            bank_re[nx][x * gy + gy - 1] = 0; bank_im[nx][x * gy + gy - 1] = 0;
         end
         for (int y = 0; y < gy; y++) begin
            bank_re[nx][y] = 0;               bank_im[nx][y] = 0;
            bank_re[nx][(gx - 1) * gy + y] = 0; bank_im[nx][(gx - 1) * gy + y] = 0;
         end
         rot = (rot + 1) % 3;
      endfunction

      // Note an accepted request and queue its answer
      function void note_request(request_type r);
         answer_type  a;
         int          gx, gy, cu, xl, yl, xh, yh, fx, fy;
         logic [63:0] d11, d21, d12, d22, lo, hi, v;
         gx = grid_size(gx_reg);
         gy = grid_size(gy_reg);
         cu = (rot + 1) % 3;
         a.density = 0;
         a.status = 0;
         case (r.action)
            ACT_LOAD: begin
               if (r.px < gx && r.py < gy) begin
                  bank_re[cu][r.px * gy + r.py] = longint'($signed(r.re));
                  bank_im[cu][r.px * gy + r.py] = longint'($signed(r.im));
               end else begin
                  a.status = 1;
               end
            end
            ACT_STEP: advance_field();
            ACT_QUERY: begin
               xl = r.qx >> 8; fx = r.qx & 8'hFF;
               yl = r.qy >> 8; fy = r.qy & 8'hFF;
               xh = xl + (fx != 0); yh = yl + (fy != 0);
               if (xh >= gx || yh >= gy) begin
                  a.status = 1;
               end else begin
                  d11 = corner_power(cu, xl * gy + yl);
                  d21 = corner_power(cu, xh * gy + yl);
                  d12 = corner_power(cu, xl * gy + yh);
                  d22 = corner_power(cu, xh * gy + yh);
                  lo = d11 * (256 - fx) + d21 * fx;
                  hi = d12 * (256 - fx) + d22 * fx;
                  v = (lo * (256 - fy) + hi * fy + 64'h8000) >> 16;
                  a.density = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
               end
            end
            default: ;
         endcase
         pending.push_back(a);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      // Compare one answer with the oldest promise
      task check_answer(logic [31:0] density, logic status);
         answer_type a;
         if (pending.size() == 0) begin
            report_mismatch("unexpected answer", density, 0);
         end else begin
            a = pending.pop_front();
            if (density !== a.density) report_mismatch("density", density, a.density);
            if (status !== a.status) report_mismatch("status", 32'(status), 32'(a.status));
         end
      endtask
   endclass

   logic        clock, reset, start, busy;
   logic [1:0]  req_action;
   logic [6:0]  req_point_x, req_point_y;
   logic signed [31:0] req_real_part, req_imag_part;
   logic [14:0] req_query_x, req_query_y;
   logic        rsp_valid, rsp_status;
   logic [31:0] rsp_density;
   logic        csr_we;
   logic [CSR_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   field_scoreboard sb;
   logic quiet;

   schrodinger_grid_stencil_step_core dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Check every answer on the strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_answer(rsp_density, rsp_status);
   end

   // Issue one request after a drawn gap and hold it until taken
   task send(request_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1;
      req_action    <= r.action;
      req_point_x   <= r.px;
      req_point_y   <= r.py;
      req_real_part <= r.re;
      req_imag_part <= r.im;
      req_query_x   <= r.qx;
      req_query_y   <= r.qy;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
   endtask

   // Drain: drop start and wait until no answer is pending and the block is idle
   task drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all six registers back to back
   task write_regs(logic [47:0] v[6]);
      csr_we <= 1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= CSR_BITS'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         sb.write_reg(csr_index_type'(i), v[i]);
      end
      csr_we <= 0;
   endtask

   function automatic logic [31:0] pick_part();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom) >>> 6);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom) >>> 3);
      endcase
   endfunction

   function automatic request_type make(action_type a, int px, int py, logic [31:0] re,
                                        logic [31:0] im, int qx, int qy);
      request_type r;
      r.action = a; r.px = 7'(px); r.py = 7'(py); r.re = re; r.im = im;
      r.qx = 15'(qx); r.qy = 15'(qy);
      return r;
   endfunction

   function automatic request_type random_request(int gx, int gy);
      int k;
      k = $urandom_range(0, 99);
      if (k < 45)
         return make(ACT_LOAD,
                     k < 40 ? $urandom_range(0, gx - 1) : $urandom_range(0, 127),
                     k < 40 ? $urandom_range(0, gy - 1) : $urandom_range(0, 127),
                     pick_part(), pick_part(), $urandom, $urandom);
      if (k < 62)
         return make(ACT_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (k < 95)
         return make(ACT_QUERY, $urandom, $urandom, $urandom, $urandom,
                     k < 90 ? $urandom_range(0, (gx - 1) * 256) : $urandom_range(0, 32767),
                     k < 90 ? $urandom_range(0, (gy - 1) * 256) : $urandom_range(0, 32767));
      return make(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   initial begin
      logic [47:0] regs[6];
      int gx, gy;
      sb = new();
      quiet = 0;
      reset <= 1; start <= 0; csr_we <= 0; csr_index <= '0; csr_wdata <= '0;
      req_action <= ACT_NONE; req_point_x <= '0; req_point_y <= '0;
      req_real_part <= '0; req_imag_part <= '0; req_query_x <= '0; req_query_y <= '0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed: full grid at reset, field extremes, query edges, unused code
      send(make(ACT_LOAD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
      send(make(ACT_LOAD, 127, 127, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
      send(make(ACT_LOAD, 1, 0, 32'h0800_0000, 32'hF800_0000, 0, 0));
      send(make(ACT_LOAD, 127, 0, 32'h1234_5678, 32'hFEDC_BA98, 0, 0));
      send(make(ACT_QUERY, 0, 0, 0, 0, 0, 0));
      send(make(ACT_QUERY, 0, 0, 0, 0, 128, 0));
      send(make(ACT_QUERY, 0, 0, 0, 0, 1, 255));
      send(make(ACT_QUERY, 0, 0, 0, 0, 127 * 256, 127 * 256));
      send(make(ACT_QUERY, 0, 0, 0, 0, 127 * 256 + 1, 0));
      send(make(ACT_QUERY, 0, 0, 0, 0, 32767, 32767));
      send(make(ACT_NONE, 127, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32767, 32767));
      drain();

      // Directed: smallest grid, saturating coefficients, both schemes
      regs = '{48'hFFFF_FFFF, 48'h8000_0000, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd0, 48'd2};
      write_regs(regs);
      send(make(ACT_LOAD, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
      send(make(ACT_LOAD, 3, 0, 1, 1, 0, 0));
      send(make(ACT_LOAD, 0, 3, 1, 1, 0, 0));
      send(make(ACT_STEP, 0, 0, 0, 0, 0, 0));
      send(make(ACT_QUERY, 0, 0, 0, 0, 384, 384));
      send(make(ACT_QUERY, 0, 0, 0, 0, 256, 256));
      drain();
      regs = '{48'h0000_4000, 48'h7FFF_FFFF, 48'd1, 48'd1, 48'd255, 48'd4};
      write_regs(regs);
      send(make(ACT_LOAD, 127, 2, 32'h0100_0000, 32'h0200_0000, 0, 0));
      send(make(ACT_LOAD, 5, 1, 32'h0100_0000, 32'h0200_0000, 0, 0));
      send(make(ACT_STEP, 0, 0, 0, 0, 0, 0));
      send(make(ACT_STEP, 0, 0, 0, 0, 0, 0));
      send(make(ACT_QUERY, 0, 0, 0, 0, 5 * 256 + 77, 1 * 256 + 200));
      drain();

      // Random phases: seed part of the grid, then a mix of loads, steps, queries and unused codes
      for (int ph = 0; ph < 3; ph++) begin
         regs[0] = $urandom_range(0, 1) ? 48'($urandom_range(0, 1 << 22)) : 48'($urandom);
         regs[1] = $urandom_range(0, 1) ? 48'($urandom) : 48'($urandom_range(0, 1 << 26));
         regs[2] = $urandom_range(0, 1) ? 48'({$urandom, $urandom})
                                        : 48'($urandom_range(0, 65535));
         regs[3] = 48'($urandom_range(0, 1));
         regs[4] = 48'($urandom_range(0, 9));
         regs[5] = 48'($urandom_range(0, 9));
         write_regs(regs);
         gx = sb.grid_size(int'(regs[4]));
         gy = sb.grid_size(int'(regs[5]));
         for (int x = 0; x < gx; x++)
            for (int y = 0; y < gy; y++)
               if ($urandom_range(0, 3) == 0)
                  send(make(ACT_LOAD, x, y, pick_part(), pick_part(), 0, 0));
         for (int n = 0; n < 18; n++) send(random_request(gx, gy));
         drain();
      end

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[schrodinger_grid_stencil_step_core.f]
hdl/sgs_pkg.sv
hdl/sgs_bank.sv
hdl/sgs_mul.sv
hdl/schrodinger_grid_stencil_step_core.sv
tb/tb.sv
